// File: hdl/npch_pkg.sv
package npch_pkg;

   // stack geometry
   localparam int MAX_DEPTH = 16;
   localparam int LEVEL_W   = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W     = $clog2(MAX_DEPTH);

   // reflected crc-32
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // queue between front and back
   localparam int OPQ_DEPTH = 4;
   localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

   // result queue
   localparam int RSQ_DEPTH = 2;
   localparam int RSQ_PTR_W = $clog2(RSQ_DEPTH);
   localparam int RSQ_CNT_W = $clog2(RSQ_DEPTH + 1);

   typedef enum logic [2:0] {
      ACT_OPEN_ARRAY = 3'd0,
      ACT_OPEN_MAP   = 3'd1,
      ACT_KEY        = 3'd2,
      ACT_VALUE      = 3'd3,
      ACT_CLOSE      = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } error_type;

   typedef enum logic [2:0] {
      OP_OPEN_ARRAY = 3'd0,
      OP_OPEN_MAP   = 3'd1,
      OP_KEY        = 3'd2,
      OP_VALUE      = 3'd3,
      OP_CLOSE      = 3'd4,
      OP_ERROR      = 3'd5
   } op_kind_type;

   // classified item handed from front to back
   typedef struct packed {
      op_kind_type        kind;
      logic [LEVEL_W-1:0] level;
      logic [7:0]         data;
      logic               valid;
      logic               first;
      logic               last;
      error_type          err;
   } op_type;

   typedef struct packed {
      logic [31:0] hash;
      error_type   err;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } opq_status_type;

   // one byte through the reflected crc
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: hdl/npch_front.sv
module npch_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [2:0]             req_action,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_byte_valid,
   input  logic                   req_first_byte,
   input  logic                   req_last_byte,
   input  npch_pkg::opq_status_type q_status,
   output logic                   full,
   output logic                   q_push,
   output npch_pkg::op_type       q_op
);

   logic [npch_pkg::LEVEL_W-1:0] level_ff;
   logic [npch_pkg::LEVEL_W-1:0] level_in;
   logic [npch_pkg::LEVEL_W-1:0] level_next;
   logic                         accept;
   logic                         enq;

   assign full   = q_status.full;
   assign accept = push && !full;
   assign q_push = accept && enq;

   // classify the item and track the open level count
   always_comb begin
      enq        = 1'b1;
      level_next = level_ff;
      q_op.kind  = npch_pkg::OP_KEY;
      q_op.level = level_ff;
      q_op.data  = req_data_byte;
      q_op.valid = req_byte_valid;
      q_op.first = req_first_byte;
      q_op.last  = req_last_byte;
      q_op.err   = npch_pkg::ERR_NONE;
      unique case (npch_pkg::action_type'(req_action)) inside
         npch_pkg::ACT_OPEN_ARRAY, npch_pkg::ACT_OPEN_MAP: begin
            if (level_ff == npch_pkg::LEVEL_W'(npch_pkg::MAX_DEPTH)) begin
               q_op.kind = npch_pkg::OP_ERROR;
               q_op.err  = npch_pkg::ERR_OVERFLOW;
            end else begin
               q_op.kind  = (npch_pkg::action_type'(req_action) == npch_pkg::ACT_OPEN_ARRAY) ?
                            npch_pkg::OP_OPEN_ARRAY : npch_pkg::OP_OPEN_MAP;
               level_next = level_ff + 1'b1;
            end
         end
         npch_pkg::ACT_KEY: begin
            q_op.kind = npch_pkg::OP_KEY;
         end
         npch_pkg::ACT_VALUE: begin
            q_op.kind = npch_pkg::OP_VALUE;
         end
         npch_pkg::ACT_CLOSE: begin
            if (level_ff == '0) begin
               q_op.kind = npch_pkg::OP_ERROR;
               q_op.err  = npch_pkg::ERR_UNDERFLOW;
            end else begin
               q_op.kind  = npch_pkg::OP_CLOSE;
               level_next = level_ff - 1'b1;
            end
         end
         default: begin
            enq = 1'b0;
         end
      endcase
      level_in = accept ? level_next : level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

endmodule

// File: hdl/npch_op_queue.sv
module npch_op_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  npch_pkg::op_type         wr_op,
   input  logic                     rd_en,
   output npch_pkg::op_type         rd_op,
   output npch_pkg::opq_status_type status
);

   npch_pkg::op_type               entry_ff [npch_pkg::OPQ_DEPTH];
   logic [npch_pkg::OPQ_PTR_W-1:0] wr_ptr_ff;
   logic [npch_pkg::OPQ_PTR_W-1:0] wr_ptr_in;
   logic [npch_pkg::OPQ_PTR_W-1:0] rd_ptr_ff;
   logic [npch_pkg::OPQ_PTR_W-1:0] rd_ptr_in;
   logic [npch_pkg::OPQ_CNT_W-1:0] count_ff;
   logic [npch_pkg::OPQ_CNT_W-1:0] count_in;
   logic                           do_wr;
   logic                           do_rd;

   assign status.full  = (count_ff == npch_pkg::OPQ_CNT_W'(npch_pkg::OPQ_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;
   assign rd_op        = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == npch_pkg::OPQ_PTR_W'(npch_pkg::OPQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == npch_pkg::OPQ_PTR_W'(npch_pkg::OPQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_op;
      end
   end

endmodule

// File: hdl/npch_back.sv
module npch_back (
   input  logic                     clock,
   input  logic                     reset,
   input  npch_pkg::op_type         op,
   input  npch_pkg::opq_status_type q_status,
   output logic                     q_pop,
   input  logic                     pop,
   output logic                     empty,
   output logic [31:0]              rsp_path_hash,
   output logic [1:0]               rsp_error_code
);

   // level crc stack, top entry mirrored in a register
   logic [31:0]                  stack_ff [npch_pkg::MAX_DEPTH];
   logic [31:0]                  top_ff;
   logic [31:0]                  top_in;
   logic [31:0]                  working_ff;
   logic [31:0]                  working_in;
   logic                         st_we;
   logic [npch_pkg::IDX_W-1:0]   st_addr;
   logic [31:0]                  st_data;
   logic [npch_pkg::IDX_W-1:0]   par_idx;
   logic [31:0]                  parent;
   logic [31:0]                  base;
   logic [31:0]                  hashed;
   logic [31:0]                  key_done;
   logic [31:0]                  arr_prefix;
   logic                         makes_rsp;
   logic                         go;

   // result queue
   npch_pkg::rsp_type              rsq_ff [npch_pkg::RSQ_DEPTH];
   logic [npch_pkg::RSQ_PTR_W-1:0] rsq_wr_ff;
   logic [npch_pkg::RSQ_PTR_W-1:0] rsq_wr_in;
   logic [npch_pkg::RSQ_PTR_W-1:0] rsq_rd_ff;
   logic [npch_pkg::RSQ_PTR_W-1:0] rsq_rd_in;
   logic [npch_pkg::RSQ_CNT_W-1:0] rsq_cnt_ff;
   logic [npch_pkg::RSQ_CNT_W-1:0] rsq_cnt_in;
   logic                           rsq_full;
   logic                           rsq_we;
   logic                           rsq_re;
   npch_pkg::rsp_type              rsq_data;

   assign rsq_full = (rsq_cnt_ff == npch_pkg::RSQ_CNT_W'(npch_pkg::RSQ_DEPTH));
   assign empty    = (rsq_cnt_ff == '0);
   assign rsq_re   = pop && !empty;

   // issue when the op leaves no result or the result queue has room
   assign makes_rsp = (op.kind == npch_pkg::OP_ERROR) ||
                      ((op.kind == npch_pkg::OP_VALUE) && op.last);
   assign go        = !q_status.empty && (!makes_rsp || !rsq_full);
   assign q_pop     = go;

   // parent level crc, also the new top after a close
   assign par_idx = npch_pkg::IDX_W'(op.level - npch_pkg::LEVEL_W'(2));
   assign parent  = (op.level < npch_pkg::LEVEL_W'(2)) ? npch_pkg::CRC_INIT : stack_ff[par_idx];

   // byte hashing datapath
   always_comb begin
      if (op.first) begin
         base = (op.kind == npch_pkg::OP_KEY) ? parent : top_ff;
      end else begin
         base = working_ff;
      end
      hashed     = op.valid ? npch_pkg::crc_byte(base, op.data) : base;
      key_done   = npch_pkg::crc_byte(hashed, 8'd0);
      arr_prefix = npch_pkg::crc_byte(top_ff, 8'd0);
   end

   // execute one op
   always_comb begin
      top_in        = top_ff;
      working_in    = working_ff;
      st_we         = 1'b0;
      st_addr       = op.level[npch_pkg::IDX_W-1:0];
      st_data       = top_ff;
      rsq_we        = 1'b0;
      rsq_data.hash = 32'd0;
      rsq_data.err  = op.err;
      if (go) begin
         unique case (op.kind)
            npch_pkg::OP_OPEN_ARRAY: begin
               st_we   = 1'b1;
               st_data = arr_prefix;
               top_in  = arr_prefix;
            end
            npch_pkg::OP_OPEN_MAP: begin
               st_we = 1'b1;
            end
            npch_pkg::OP_KEY: begin
               working_in = op.last ? key_done : hashed;
               if (op.last && (op.level != '0)) begin
                  st_we   = 1'b1;
                  st_addr = npch_pkg::IDX_W'(op.level - 1'b1);
                  st_data = key_done;
                  top_in  = key_done;
               end
            end
            npch_pkg::OP_VALUE: begin
               working_in = hashed;
               if (op.last) begin
                  rsq_we        = 1'b1;
                  rsq_data.hash = ~hashed;
                  rsq_data.err  = npch_pkg::ERR_NONE;
               end
            end
            npch_pkg::OP_CLOSE: begin
               top_in = parent;
            end
            npch_pkg::OP_ERROR: begin
               rsq_we = 1'b1;
            end
            default: begin
               rsq_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= npch_pkg::CRC_INIT;
         working_ff <= npch_pkg::CRC_INIT;
      end else begin
         top_ff     <= top_in;
         working_ff <= working_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stack_ff[st_addr] <= st_data;
      end
   end

   // result queue pointers
   always_comb begin
      rsq_wr_in  = rsq_wr_ff;
      rsq_rd_in  = rsq_rd_ff;
      rsq_cnt_in = rsq_cnt_ff;
      if (rsq_we) begin
         rsq_wr_in = (rsq_wr_ff == npch_pkg::RSQ_PTR_W'(npch_pkg::RSQ_DEPTH - 1)) ?
                     '0 : rsq_wr_ff + 1'b1;
      end
      if (rsq_re) begin
         rsq_rd_in = (rsq_rd_ff == npch_pkg::RSQ_PTR_W'(npch_pkg::RSQ_DEPTH - 1)) ?
                     '0 : rsq_rd_ff + 1'b1;
      end
      if (rsq_we && !rsq_re) begin
         rsq_cnt_in = rsq_cnt_ff + 1'b1;
      end else if (rsq_re && !rsq_we) begin
         rsq_cnt_in = rsq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsq_wr_ff  <= '0;
         rsq_rd_ff  <= '0;
         rsq_cnt_ff <= '0;
      end else begin
         rsq_wr_ff  <= rsq_wr_in;
         rsq_rd_ff  <= rsq_rd_in;
         rsq_cnt_ff <= rsq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsq_we) begin
         rsq_ff[rsq_wr_ff] <= rsq_data;
      end
   end

   assign rsp_path_hash  = rsq_ff[rsq_rd_ff].hash;
   assign rsp_error_code = rsq_ff[rsq_rd_ff].err;

endmodule

// File: hdl/nested_path_crc_hasher.sv
// a result reaches the rsp ports through the registered op queue and result queue
// throughput: one item per cycle unless full; the back end runs one op per cycle while ops
// wait and results have room, a byte-wise crc update plus one stack read and one stack write
// a 4-entry op queue decouples classification from hashing; results wait in a 2-entry queue
// reset (synchronous, active high) empties both queues, closes all levels, crc state all ones
module nested_path_crc_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_path_hash,
   output logic [1:0]  rsp_error_code
);

   npch_pkg::opq_status_type q_status;
   npch_pkg::op_type         q_wr_op;
   npch_pkg::op_type         q_rd_op;
   logic                     q_push;
   logic                     q_pop;

   // front: transfer in, level tracking, classification
   npch_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_byte_valid (req_byte_valid),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .q_status       (q_status),
      .full           (full),
      .q_push         (q_push),
      .q_op           (q_wr_op)
   );

   // op queue between front and back
   npch_op_queue u_op_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_push),
      .wr_op  (q_wr_op),
      .rd_en  (q_pop),
      .rd_op  (q_rd_op),
      .status (q_status)
   );

   // back: crc datapath, level stack, result queue
   npch_back u_back (
      .clock          (clock),
      .reset          (reset),
      .op             (q_rd_op),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_path_hash  (rsp_path_hash),
      .rsp_error_code (rsp_error_code)
   );

   // back never issues from an empty op queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("op issued from empty queue");

   // front never writes into a full op queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("op written into full queue");

   // error results carry a zero hash
   assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_error_code != npch_pkg::ERR_NONE)) |-> (rsp_path_hash == 32'd0))
      else $error("error result with nonzero hash");

   // no result waits right after reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("result pending after reset");

endmodule

// File: verif/tb_nested_path_crc_hasher.sv
`timescale 1ns / 1ps

module tb_nested_path_crc_hasher;

   // action codes the block ignores
   localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;

   localparam logic [7:0]  SEP_BYTE    = 8'h00;
   localparam logic [31:0] ROOT_PREFIX = 32'hFFFF_FFFF;

   localparam int ITEM_TARGET     = 1450;
   localparam int IDLE_PERCENT    = 37;
   localparam int QUIET_FROM      = 900;
   localparam int QUIET_TO        = 1500;
   localparam int FIRST_STALL_AT  = 30;
   localparam int SECOND_STALL_AT = 150;
   localparam int STALL_CYCLES    = 100;
   localparam int SETTLE_CYCLES   = 10;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct {
      logic [2:0] action;
      logic [7:0] data;
      logic       valid;
      logic       first;
      logic       last;
      bit         drain;
   } doc_token_type;

   typedef struct packed {
      logic [31:0]         hash;
      npch_pkg::error_type err;
   } leaf_hash_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_action = npch_pkg::ACT_OPEN_ARRAY;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [31:0] rsp_path_hash;
   logic [1:0]  rsp_error_code;

   doc_token_type  token_queue[$];
   leaf_hash_type  expected_hashes[$];

   // path prefix state mirrored from the block
   logic [31:0] level_prefix[npch_pkg::MAX_DEPTH];
   int unsigned open_levels = 0;
   logic [31:0] running_crc = ROOT_PREFIX;

   // generator's view of the open levels, 1 for a map
   bit          gen_levels[$];
   int          gen_items = 0;

   int          cycle_count = 0;
   int          fail_count = 0;
   int          items_taken = 0;
   int          results_checked = 0;
   int          overflow_seen = 0;
   int          underflow_seen = 0;
   int          deepest = 0;
   int          stall_left = 0;
   int          stall_index = 0;
   logic        quiet_stretch;

   nested_path_crc_hasher i_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_byte_valid (req_byte_valid),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .empty          (empty),
      .pop            (pop),
      .rsp_path_hash  (rsp_path_hash),
      .rsp_error_code (rsp_error_code)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   assign quiet_stretch = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

   // reflected crc-32, one input bit per step
   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r = r >> 1;
         if (fb) r = r ^ npch_pkg::CRC_POLY;
      end
      return r;
   endfunction

   // advance the path state by one taken item, queue any leaf hash or error
   task automatic hash_token(input logic [2:0] act, input logic [7:0] data,
                             input logic valid, input logic first, input logic last);
      logic [31:0] prefix;
      case (act)
         npch_pkg::ACT_OPEN_ARRAY, npch_pkg::ACT_OPEN_MAP: begin
            if (open_levels >= npch_pkg::MAX_DEPTH) begin
               expected_hashes.push_back('{hash: 32'd0, err: npch_pkg::ERR_OVERFLOW});
               overflow_seen++;
            end else begin
               prefix = (open_levels == 0) ? ROOT_PREFIX : level_prefix[open_levels - 1];
               if (act == npch_pkg::ACT_OPEN_ARRAY) prefix = crc_step(prefix, SEP_BYTE);
               level_prefix[open_levels] = prefix;
               open_levels++;
               if (open_levels > deepest) deepest = open_levels;
            end
         end
         npch_pkg::ACT_KEY: begin
            if (first) running_crc = (open_levels < 2) ? ROOT_PREFIX
                                                       : level_prefix[open_levels - 2];
            if (valid) running_crc = crc_step(running_crc, data);
            if (last) begin
               running_crc = crc_step(running_crc, SEP_BYTE);
               if (open_levels != 0) level_prefix[open_levels - 1] = running_crc;
            end
         end
         npch_pkg::ACT_VALUE: begin
            if (first) running_crc = (open_levels == 0) ? ROOT_PREFIX
                                                        : level_prefix[open_levels - 1];
            if (valid) running_crc = crc_step(running_crc, data);
            if (last) expected_hashes.push_back('{hash: ~running_crc, err: npch_pkg::ERR_NONE});
         end
         npch_pkg::ACT_CLOSE: begin
            if (open_levels == 0) begin
               expected_hashes.push_back('{hash: 32'd0, err: npch_pkg::ERR_UNDERFLOW});
               underflow_seen++;
            end else begin
               open_levels--;
            end
         end
         default: ;
      endcase
   endtask

   // stimulus building
   task automatic add_item(input logic [2:0] act, input logic [7:0] data,
                           input logic valid, input logic first, input logic last);
      token_queue.push_back('{act, data, valid, first, last, 1'b0});
      if (act <= npch_pkg::ACT_CLOSE) gen_items++;
      if ((act == npch_pkg::ACT_OPEN_ARRAY || act == npch_pkg::ACT_OPEN_MAP) &&
          gen_levels.size() < npch_pkg::MAX_DEPTH)
         gen_levels.push_back(act == npch_pkg::ACT_OPEN_MAP);
      else if (act == npch_pkg::ACT_CLOSE && gen_levels.size() > 0)
         void'(gen_levels.pop_back());
   endtask

   task automatic add_drain();
      token_queue.push_back('{npch_pkg::ACT_OPEN_ARRAY, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1});
   endtask

   task automatic add_text(input logic [2:0] act, input string s, input bit zero_end);
      int n;
      n = s.len() + (zero_end ? 1 : 0);
      for (int i = 0; i < n; i++)
         add_item(act, (i < s.len()) ? s[i] : SEP_BYTE, 1'b1, i == 0, i == n - 1);
   endtask

   task automatic add_random_text(input logic [2:0] act, input int max_len);
      int len;
      bit carry_on;
      len = $urandom_range(max_len, 0);
      carry_on = ($urandom_range(99) < 5);
      if (len == 0)
         add_item(act, 8'($urandom), 1'b0, 1'b1, 1'b1);
      else
         for (int i = 0; i < len; i++)
            add_item(act, 8'($urandom), $urandom_range(99) >= 8, (i == 0) && !carry_on,
                     i == len - 1);
   endtask

   // leaf as the feeder would hand it over
   task automatic add_leaf();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) add_text(npch_pkg::ACT_VALUE, " t", 1'b0);
      else if (pick < 10) add_text(npch_pkg::ACT_VALUE, " f", 1'b0);
      else if (pick < 15) add_text(npch_pkg::ACT_VALUE, "NULL", 1'b1);
      else add_random_text(npch_pkg::ACT_VALUE, 6);
   endtask

   task automatic add_open();
      add_item($urandom_range(1) ? npch_pkg::ACT_OPEN_MAP : npch_pkg::ACT_OPEN_ARRAY,
               8'($urandom), 1'(($urandom)), 1'($urandom), 1'($urandom));
   endtask

   // nest down to the top of the stack, then one open too many and a leaf
   task automatic add_dive();
      while (gen_levels.size() < npch_pkg::MAX_DEPTH) add_open();
      add_open();
      add_leaf();
   endtask

   task automatic add_noise();
      logic [2:0] act;
      if ($urandom_range(9) == 0)
         act = 3'($urandom_range(ACT_RESERVED_LAST, ACT_RESERVED_FIRST));
      else
         act = 3'($urandom_range(npch_pkg::ACT_CLOSE, npch_pkg::ACT_OPEN_ARRAY));
      add_item(act, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic build_document();
      int pick;
      bit mid_drain_done;
      mid_drain_done = 1'b0;
      add_dive();
      while (gen_items < ITEM_TARGET) begin
         if (!mid_drain_done && gen_items >= ITEM_TARGET / 2) begin
            add_drain();
            mid_drain_done = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            add_noise();
         end else if (pick < 10) begin
            add_dive();
         end else begin
            pick = $urandom_range(99);
            if (gen_levels.size() == 0) begin
               if (pick < 60) add_open();
               else if (pick < 75) add_leaf();
               else if (pick < 85) add_random_text(npch_pkg::ACT_KEY, 5);
               else add_item(npch_pkg::ACT_CLOSE, 8'($urandom), 1'b0, 1'b0, 1'b0);
            end else if (gen_levels[$]) begin
               if (pick < 20) add_item(npch_pkg::ACT_CLOSE, 8'($urandom), 1'b0, 1'b0, 1'b0);
               else if (pick < 35) begin
                  add_random_text(npch_pkg::ACT_KEY, 5);
                  add_open();
               end else if (pick < 90) begin
                  add_random_text(npch_pkg::ACT_KEY, 5);
                  add_leaf();
               end else add_leaf();
            end else begin
               if (pick < 20) add_item(npch_pkg::ACT_CLOSE, 8'($urandom), 1'b0, 1'b0, 1'b0);
               else if (pick < 35) add_open();
               else add_leaf();
            end
         end
      end
   endtask

   // item transfers update the prediction
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && push && !full) begin
         hash_token(req_action, req_data_byte, req_byte_valid, req_first_byte, req_last_byte);
         void'(token_queue.pop_front());
         if (req_action <= npch_pkg::ACT_CLOSE) items_taken++;
      end
   end

   // driver
   always @(negedge clock) begin
      bit hold_off;
      hold_off = !quiet_stretch && ($urandom_range(99) < IDLE_PERCENT);
      if (reset || token_queue.size() == 0) begin
         push <= 1'b0;
      end else if (token_queue[0].drain) begin
         push <= 1'b0;
         if (expected_hashes.size() == 0) void'(token_queue.pop_front());
      end else if (hold_off) begin
         push <= 1'b0;
      end else begin
         push           <= 1'b1;
         req_action     <= token_queue[0].action;
         req_data_byte  <= token_queue[0].data;
         req_byte_valid <= token_queue[0].valid;
         req_first_byte <= token_queue[0].first;
         req_last_byte  <= token_queue[0].last;
      end
   end

   // receiver, with two long hold-offs so the block backs up
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         pop <= 1'b0;
      end else if ((stall_index == 0 && results_checked >= FIRST_STALL_AT) ||
                   (stall_index == 1 && results_checked >= SECOND_STALL_AT)) begin
         stall_index <= stall_index + 1;
         stall_left <= STALL_CYCLES;
         pop <= 1'b0;
      end else begin
         pop <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      leaf_hash_type want;
      if (!reset && pop && !empty) begin
         results_checked++;
         if (expected_hashes.size() == 0) begin
            $error("unexpected result transfer: path_hash %h error_code %0d",
                   rsp_path_hash, rsp_error_code);
            fail_count++;
         end else begin
            want = expected_hashes.pop_front();
            if (rsp_path_hash !== want.hash) begin
               $error("path_hash mismatch: expected %h, actual %h", want.hash, rsp_path_hash);
               fail_count++;
            end
            if (rsp_error_code !== want.err) begin
               $error("error_code mismatch: expected %0d, actual %0d",
                      want.err, rsp_error_code);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      // directed part: error cases, root scalars, map and array leaves, ignored codes
      add_item(npch_pkg::ACT_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0);
      add_item(npch_pkg::ACT_VALUE, 8'hA5, 1'b0, 1'b1, 1'b1);
      add_item(npch_pkg::ACT_KEY, 8'hFF, 1'b1, 1'b1, 1'b1);
      add_text(npch_pkg::ACT_VALUE, " t", 1'b0);
      add_item(npch_pkg::ACT_OPEN_MAP, 8'h00, 1'b0, 1'b0, 1'b0);
      add_item(npch_pkg::ACT_KEY, 8'h61, 1'b1, 1'b1, 1'b1);
      add_text(npch_pkg::ACT_VALUE, "NULL", 1'b1);
      add_item(npch_pkg::ACT_OPEN_ARRAY, 8'hFF, 1'b1, 1'b1, 1'b1);
      add_item(npch_pkg::ACT_VALUE, 8'h00, 1'b1, 1'b1, 1'b1);
      add_item(npch_pkg::ACT_VALUE, 8'hFF, 1'b1, 1'b1, 1'b1);
      add_item(npch_pkg::ACT_VALUE, 8'h5A, 1'b1, 1'b0, 1'b1);
      add_text(npch_pkg::ACT_VALUE, " f", 1'b0);
      add_item(npch_pkg::ACT_CLOSE, 8'hFF, 1'b1, 1'b1, 1'b1);
      add_item(npch_pkg::ACT_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0);
      add_item(ACT_RESERVED_FIRST, 8'hFF, 1'b1, 1'b1, 1'b1);
      add_item(ACT_RESERVED_LAST, 8'h00, 1'b1, 1'b0, 1'b1);
      add_drain();
      build_document();

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // let every item go in, then let the results drain
      while (token_queue.size() != 0) @(posedge clock);
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_hashes.size() != 0) begin
         $error("%0d predicted results never arrived", expected_hashes.size());
         fail_count++;
      end
      $display("run took %0d items and checked %0d results in %0d cycles",
               items_taken, results_checked, cycle_count);
      $display("overflow flags %0d, underflow flags %0d, nesting reached %0d levels",
               overflow_seen, underflow_seen, deepest);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: nested_path_crc_hasher.f
hdl/npch_pkg.sv
hdl/npch_front.sv
hdl/npch_op_queue.sv
hdl/npch_back.sv
hdl/nested_path_crc_hasher.sv
verif/tb_nested_path_crc_hasher.sv
